/* src/toki_pkg.sv */
// ----------------------------------------------------------------------------
// toki_pkg
// Shared types and codes for the time-ordered key index.
// ----------------------------------------------------------------------------
package toki_pkg;

  localparam int TABLE_DEPTH_DEF = 64;

  localparam logic [2:0] ACT_UPSERT = 3'd0;
  localparam logic [2:0] ACT_ERASE  = 3'd1;
  localparam logic [2:0] ACT_LATEST = 3'd2;
  localparam logic [2:0] ACT_BEFORE = 3'd3;
  localparam logic [2:0] ACT_AFTER  = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam logic signed [63:0] TIME_MIN = 64'sh8000_0000_0000_0000;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_MARK,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_t;

  typedef struct packed {
    logic              valid;
    logic [63:0]       key;
    logic signed [63:0] tstamp;
  } cell_t;

  typedef struct packed {
    cell_op_t           op;
    logic               below;
    logic [63:0]        key;
    logic signed [63:0] tstamp;
  } cell_ctrl_t;

endpackage

/* src/toki_cell.sv */
// ----------------------------------------------------------------------------
// toki_cell
// One table slot: holds a key and timestamp, shifts toward either neighbor.
// ----------------------------------------------------------------------------
module toki_cell (
  input  logic                clk,
  input  logic                rst,
  input  toki_pkg::cell_ctrl_t ctrl,
  input  toki_pkg::cell_t     from_prev,
  input  logic                prev_ins,
  input  toki_pkg::cell_t     from_next,
  input  logic                next_hit,
  input  logic                del_here,
  output toki_pkg::cell_t     cur,
  output logic                ins,
  output logic                hit,
  output logic                match
);
  import toki_pkg::*;

  cell_t ent;
  logic  hit_q;
  logic  match_q;
  logic  time_hit;

  assign ins = !ent.valid || ($signed(ctrl.tstamp) < $signed(ent.tstamp));
  assign time_hit = ctrl.below ? ($signed(ent.tstamp) < $signed(ctrl.tstamp))
                               : ($signed(ctrl.tstamp) < $signed(ent.tstamp));

  always_ff @(posedge clk) begin
    if (rst) begin
      ent.valid <= 1'b0;
      hit_q     <= 1'b0;
      match_q   <= 1'b0;
    end else begin
      unique case (ctrl.op)
        CELL_MARK: begin
          match_q <= ent.valid && (ent.key == ctrl.key);
          hit_q   <= ent.valid && time_hit;
        end
        CELL_INS: begin
          if (prev_ins) begin
            ent <= from_prev;
          end else if (ins) begin
            ent <= cell_t'{valid: 1'b1, key: ctrl.key, tstamp: ctrl.tstamp};
          end
        end
        CELL_DEL: begin
          if (del_here) begin
            ent <= from_next;
          end
        end
        CELL_ROT: begin
          ent   <= from_next;
          hit_q <= next_hit;
        end
        default: ;
      endcase
    end
  end

  assign cur   = ent;
  assign hit   = hit_q;
  assign match = match_q;

endmodule

/* src/time_ordered_key_index.sv */
// ----------------------------------------------------------------------------
// time_ordered_key_index
// Sorted key/timestamp table built as a chain of shifting cells.
// ----------------------------------------------------------------------------
// One request is taken at a time. Every request first marks key and time
// matches in all cells (S_MARK), then decides (S_EVAL); an upsert that is not
// refused as full then shifts the new key in (S_INS), for a moved key after
// deleting the old entry (S_DEL), and an erase that hits deletes (S_DEL). A
// range query rotates the whole chain once through cell 0, which is the only
// place entries are read out; a query that matches nothing ends after the
// deciding step. The deciding step and each rotation step that reaches a
// matching entry also wait for as long as out_ready holds back a result.
module time_ordered_key_index #(
  parameter int TABLE_DEPTH = toki_pkg::TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         action,
  input  logic [63:0]        item_key,
  input  logic signed [63:0] item_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_key,
  output logic signed [63:0] out_time,
  output logic               found,
  output logic [1:0]         status,
  output logic               last
);
  import toki_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH);

  typedef enum logic [2:0] {S_IDLE, S_MARK, S_EVAL, S_DEL, S_INS, S_ROT} state_t;

  state_t             state;
  logic [2:0]         act_q;
  logic [63:0]        key_q;
  logic signed [63:0] time_q;
  logic [CW-1:0]      rot_cnt;

  cell_ctrl_t         ctrl;
  cell_t              cells   [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] ins_v;
  logic [TABLE_DEPTH-1:0] hit_v;
  logic [TABLE_DEPTH-1:0] match_v;
  logic [TABLE_DEPTH-1:0] tail_v;
  cell_t              wrap_in;

  logic               slot_free;
  logic               rot_step;
  logic               any_match;
  logic               any_hit;
  logic               empty;
  logic               full;
  logic               more_hits;
  logic signed [63:0] latest_time;
  logic signed [63:0] old_time;

  assign in_ready  = (state == S_IDLE);
  assign slot_free = !out_valid || out_ready;
  assign rot_step  = !hit_v[0] || slot_free;
  assign any_match = |match_v;
  assign any_hit   = |hit_v;
  assign empty     = !cells[0].valid;
  assign full      = cells[TABLE_DEPTH-1].valid;
  assign more_hits = |hit_v[TABLE_DEPTH-1:1];

  always_comb begin
    ctrl.key    = key_q;
    ctrl.tstamp = time_q;
    ctrl.below  = (act_q == ACT_BEFORE);
    unique case (state)
      S_MARK:  ctrl.op = CELL_MARK;
      S_DEL:   ctrl.op = CELL_DEL;
      S_INS:   ctrl.op = CELL_INS;
      S_ROT:   ctrl.op = rot_step ? CELL_ROT : CELL_HOLD;
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  assign wrap_in = (state == S_ROT) ? cells[0] : '0;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    cell_t prev_c;
    cell_t next_c;
    logic  prev_i;
    logic  next_h;
    if (i == 0) begin : g_head
      assign prev_c = '0;
      assign prev_i = 1'b0;
    end else begin : g_body
      assign prev_c = cells[i-1];
      assign prev_i = ins_v[i-1];
    end
    if (i == TABLE_DEPTH - 1) begin : g_tail
      assign next_c    = wrap_in;
      assign next_h    = 1'b0;
      assign tail_v[i] = cells[i].valid;
    end else begin : g_mid
      assign next_c    = cells[i+1];
      assign next_h    = hit_v[i+1];
      assign tail_v[i] = cells[i].valid && !cells[i+1].valid;
    end

    toki_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctrl      (ctrl),
      .from_prev (prev_c),
      .prev_ins  (prev_i),
      .from_next (next_c),
      .next_hit  (next_h),
      .del_here  (|match_v[i:0]),
      .cur       (cells[i]),
      .ins       (ins_v[i]),
      .hit       (hit_v[i]),
      .match     (match_v[i])
    );
  end

  always_comb begin
    latest_time = '0;
    old_time    = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      latest_time = latest_time | (tail_v[i]  ? cells[i].tstamp : 64'sd0);
      old_time    = old_time    | (match_v[i] ? cells[i].tstamp : 64'sd0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      rot_cnt   <= '0;
    end else begin
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            act_q  <= action;
            key_q  <= item_key;
            time_q <= item_time;
            state  <= S_MARK;
          end
        end
        S_MARK: begin
          state <= S_EVAL;
        end
        S_EVAL: begin
          if (slot_free) begin
            rot_cnt <= '0;
            last    <= 1'b1;
            unique case (act_q) inside
              ACT_UPSERT: begin
                out_valid <= 1'b1;
                out_key   <= key_q;
                out_time  <= time_q;
                found     <= any_match || !full;
                status    <= (!any_match && full) ? ST_FULL : ST_OK;
                state     <= any_match ? S_DEL : (full ? S_IDLE : S_INS);
              end
              ACT_ERASE: begin
                out_valid <= 1'b1;
                out_key   <= key_q;
                out_time  <= any_match ? old_time : 64'sd0;
                found     <= any_match;
                status    <= any_match ? ST_OK : ST_ABSENT;
                state     <= any_match ? S_DEL : S_IDLE;
              end
              ACT_LATEST: begin
                out_valid <= 1'b1;
                out_key   <= '0;
                out_time  <= empty ? TIME_MIN : latest_time;
                found     <= !empty;
                status    <= ST_OK;
                state     <= S_IDLE;
              end
              ACT_BEFORE, ACT_AFTER: begin
                if (any_hit) begin
                  state <= S_ROT;
                end else begin
                  out_valid <= 1'b1;
                  out_key   <= '0;
                  out_time  <= '0;
                  found     <= 1'b0;
                  status    <= ST_OK;
                  state     <= S_IDLE;
                end
              end
              default: state <= S_IDLE;
            endcase
          end
        end
        S_DEL: begin
          state <= (act_q == ACT_UPSERT) ? S_INS : S_IDLE;
        end
        S_INS: begin
          state <= S_IDLE;
        end
        S_ROT: begin
          if (rot_step) begin
            if (hit_v[0]) begin
              out_valid <= 1'b1;
              out_key   <= cells[0].key;
              out_time  <= cells[0].tstamp;
              found     <= 1'b1;
              status    <= ST_OK;
              last      <= !more_hits;
            end
            rot_cnt <= rot_cnt + 1'b1;
            if (rot_cnt == CW'(TABLE_DEPTH - 1)) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

/* src/toki_checker.sv */
// ----------------------------------------------------------------------------
// toki_checker
// Port-level checks for the time-ordered key index.
// ----------------------------------------------------------------------------
module toki_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [63:0]        out_key,
  input logic signed [63:0] out_time,
  input logic               found,
  input logic [1:0]         status,
  input logic               last
);
  import toki_pkg::*;

  a_one_request: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken on back-to-back cycles");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_key) && $stable(out_time)
      && $stable(found) && $stable(status) && $stable(last))
    else $error("stalled result changed");

  a_miss_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (found || last))
    else $error("result without match is not last");

  a_err_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status != ST_OK) |-> !found && last)
    else $error("error result marked found or not last");

  a_absent_time: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ABSENT) |-> (out_time == 64'sd0))
    else $error("absent key reports nonzero time");

endmodule

bind time_ordered_key_index toki_checker u_toki_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_key   (out_key),
  .out_time  (out_time),
  .found     (found),
  .status    (status),
  .last      (last)
);

/* tb/tb_time_ordered_key_index.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_time_ordered_key_index
// Self-checking testbench for the time-ordered key index.
// A request queue, filled up front, feeds a clocked driver: first corner cases,
// then random upsert/erase/query mixes, a fill past capacity and a drain-down.
// A shadow sorted table predicts every result at input acceptance, and a
// clocked monitor checks each output result field by field, in order.
// ----------------------------------------------------------------------------
module tb_time_ordered_key_index;
  import toki_pkg::*;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;
  localparam logic [2:0] ACT_SPARE_LO = 3'd5;
  localparam logic [2:0] ACT_SPARE_HI = 3'd7;
  localparam logic signed [63:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam int KEY_POOL_N = 72;
  localparam int IDLE_PCT = 32;
  localparam int HOLD_AT = 40;
  localparam int HOLD_CYCLES = 300;
  localparam int CALM_FROM = 150;
  localparam int CALM_TO = 215;
  localparam int WATCHDOG_LIMIT = 4000;

  typedef struct packed {
    logic               drain;
    logic [2:0]         act;
    logic [63:0]        key;
    logic signed [63:0] tstamp;
  } req_t;

  typedef struct packed {
    logic [63:0]        key;
    logic signed [63:0] tstamp;
    logic               found;
    logic [1:0]         status;
    logic               last;
  } res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         action = '0;
  logic [63:0]        item_key = '0;
  logic signed [63:0] item_time = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [63:0]        out_key;
  logic signed [63:0] out_time;
  logic               found;
  logic [1:0]         status;
  logic               last;

  req_t request_q[$];
  res_t awaited_results[$];
  req_t cur_req;
  res_t want;

  logic [63:0]        idx_key [TABLE_DEPTH];
  logic signed [63:0] idx_time[TABLE_DEPTH];
  int                 idx_fill = 0;

  logic [63:0]        key_pool [KEY_POOL_N];
  logic signed [63:0] time_pool[8];

  logic in_fire = 1'b0;
  int   accepted = 0;
  int   err_cnt = 0;
  int   quiet_cycles = 0;
  int   hold_left = 0;
  bit   hold_done = 1'b0;
  logic calm;

  assign calm = (accepted >= CALM_FROM) && (accepted < CALM_TO);

  always #1 clk = ~clk;

  time_ordered_key_index #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .action   (action),
    .item_key (item_key),
    .item_time(item_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_key  (out_key),
    .out_time (out_time),
    .found    (found),
    .status   (status),
    .last     (last)
  );

  // Shadow sorted table

  function automatic int index_find(logic [63:0] key);
    for (int i = 0; i < idx_fill; i++)
      if (idx_key[i] == key) return i;
    return -1;
  endfunction

  function automatic void index_remove(int pos);
    for (int i = pos; i + 1 < idx_fill; i++) begin
      idx_key[i]  = idx_key[i + 1];
      idx_time[i] = idx_time[i + 1];
    end
    idx_fill--;
  endfunction

  function automatic void index_insert(logic [63:0] key, logic signed [63:0] t);
    int pos;
    pos = 0;
    while (pos < idx_fill && !(t < idx_time[pos])) pos++;
    for (int i = idx_fill; i > pos; i--) begin
      idx_key[i]  = idx_key[i - 1];
      idx_time[i] = idx_time[i - 1];
    end
    idx_key[pos]  = key;
    idx_time[pos] = t;
    idx_fill++;
  endfunction

  function automatic bit range_hit(logic [2:0] act, logic signed [63:0] t_entry,
                                   logic signed [63:0] bound);
    if (act == ACT_BEFORE) return t_entry < bound;
    return bound < t_entry;
  endfunction

  function automatic void await_result(logic [63:0] key, logic signed [63:0] t,
                                      logic fnd, logic [1:0] st, logic lst);
    res_t r;
    r.key    = key;
    r.tstamp = t;
    r.found  = fnd;
    r.status = st;
    r.last   = lst;
    awaited_results = {awaited_results, r};
  endfunction

  function automatic void index_apply_request(req_t r);
    int                 pos;
    int                 hits;
    int                 seen;
    logic signed [63:0] t;
    t = r.tstamp;
    case (r.act)
      ACT_UPSERT: begin
        pos = index_find(r.key);
        if (pos >= 0) begin
          index_remove(pos);
          index_insert(r.key, t);
          await_result(r.key, t, 1'b1, ST_OK, 1'b1);
        end else if (idx_fill >= TABLE_DEPTH) begin
          await_result(r.key, t, 1'b0, ST_FULL, 1'b1);
        end else begin
          index_insert(r.key, t);
          await_result(r.key, t, 1'b1, ST_OK, 1'b1);
        end
      end
      ACT_ERASE: begin
        pos = index_find(r.key);
        if (pos < 0) begin
          await_result(r.key, '0, 1'b0, ST_ABSENT, 1'b1);
        end else begin
          await_result(r.key, idx_time[pos], 1'b1, ST_OK, 1'b1);
          index_remove(pos);
        end
      end
      ACT_LATEST: begin
        if (idx_fill == 0) await_result('0, TIME_MIN, 1'b0, ST_OK, 1'b1);
        else await_result('0, idx_time[idx_fill - 1], 1'b1, ST_OK, 1'b1);
      end
      ACT_BEFORE, ACT_AFTER: begin
        hits = 0;
        for (int i = 0; i < idx_fill; i++)
          if (range_hit(r.act, idx_time[i], t)) hits++;
        if (hits == 0) begin
          await_result('0, '0, 1'b0, ST_OK, 1'b1);
        end else begin
          seen = 0;
          for (int i = 0; i < idx_fill; i++) begin
            if (range_hit(r.act, idx_time[i], t)) begin
              seen++;
              await_result(idx_key[i], idx_time[i], 1'b1, ST_OK, seen == hits);
            end
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Stimulus helpers

  function automatic logic signed [63:0] pick_time();
    if ($urandom_range(99) < 50) return time_pool[$urandom_range(7)];
    return {$urandom, $urandom};
  endfunction

  function automatic void queue_req(logic [2:0] act, logic [63:0] key,
                                    logic signed [63:0] t);
    req_t r;
    r.drain  = 1'b0;
    r.act    = act;
    r.key    = key;
    r.tstamp = t;
    request_q = {request_q, r};
  endfunction

  function automatic void queue_drain();
    req_t r;
    r = '0;
    r.drain = 1'b1;
    request_q = {request_q, r};
  endfunction

  function automatic req_t random_request(int pool_n, int upsert_w);
    req_t r;
    int   sel;
    sel     = $urandom_range(99);
    r.drain = 1'b0;
    if ($urandom_range(99) < 85) r.key = key_pool[$urandom_range(pool_n - 1)];
    else r.key = {$urandom, $urandom};
    r.tstamp = pick_time();
    if (sel < 5) r.act = 3'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    else if (sel < 15) r.act = ACT_LATEST;
    else if (sel < 30) r.act = ACT_BEFORE;
    else if (sel < 45) r.act = ACT_AFTER;
    else if (sel < 45 + upsert_w) r.act = ACT_UPSERT;
    else r.act = ACT_ERASE;
    return r;
  endfunction

  // Input driver: hold the request until accepted, then advance
  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (request_q.size() != 0 && request_q[0].drain && awaited_results.size() == 0)
        void'(request_q.pop_front());
      if (request_q.size() == 0 || request_q[0].drain ||
          (!calm && $urandom_range(99) < IDLE_PCT)) begin
        in_valid <= 1'b0;
      end else begin
        cur_req   = request_q.pop_front();
        in_valid  <= 1'b1;
        action    <= cur_req.act;
        item_key  <= cur_req.key;
        item_time <= cur_req.tstamp;
      end
    end
  end

  // Output ready: random stalls plus one long hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left != 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!hold_done && accepted >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  // Predict on acceptance, check each result against the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      in_fire <= 1'b0;
    end else begin
      in_fire <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        index_apply_request({1'b0, action, item_key, item_time});
        accepted++;
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: out_key %h out_time %h", out_key, out_time);
          err_cnt++;
        end else begin
          want = awaited_results.pop_front();
          if (out_key !== want.key) begin
            $error("out_key: expected %h, actual %h", want.key, out_key);
            err_cnt++;
          end
          if (out_time !== want.tstamp) begin
            $error("out_time: expected %h, actual %h", want.tstamp, out_time);
            err_cnt++;
          end
          if (found !== want.found) begin
            $error("found: expected %b, actual %b", want.found, found);
            err_cnt++;
          end
          if (status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, status);
            err_cnt++;
          end
          if (last !== want.last) begin
            $error("last: expected %b, actual %b", want.last, last);
            err_cnt++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < KEY_POOL_N; i++) key_pool[i] = {$urandom, $urandom};
    time_pool[0] = TIME_MIN;
    time_pool[1] = TIME_MAX;
    time_pool[2] = 64'sd0;
    time_pool[3] = -64'sd1;
    time_pool[4] = 64'sd1;
    time_pool[5] = 64'sh0000_0001_0000_0000;
    time_pool[6] = -64'sh0000_0001_0000_0000;
    time_pool[7] = 64'sh0000_0000_8000_0000;

    // empty table
    queue_req(ACT_LATEST, '0, '0);
    queue_req(ACT_BEFORE, '0, TIME_MAX);
    queue_req(ACT_AFTER, '1, TIME_MIN);
    queue_req(ACT_ERASE, '0, '0);
    // extremes, equal times, move to the back of an equal-time run
    queue_req(ACT_UPSERT, '0, TIME_MAX);
    queue_req(ACT_UPSERT, '1, TIME_MIN);
    queue_req(ACT_UPSERT, 64'h5555_5555_5555_5555, 64'sd0);
    queue_req(ACT_UPSERT, 64'hAAAA_AAAA_AAAA_AAAA, 64'sd0);
    queue_req(ACT_UPSERT, 64'h5555_5555_5555_5555, 64'sd0);
    queue_req(ACT_LATEST, '0, '0);
    queue_req(ACT_BEFORE, '0, TIME_MAX);
    queue_req(ACT_AFTER, '0, TIME_MIN);
    queue_req(ACT_BEFORE, '0, TIME_MIN);
    queue_req(ACT_AFTER, '0, TIME_MAX);
    queue_req(ACT_BEFORE, '0, 64'sd1);
    queue_req(ACT_AFTER, '0, -64'sd1);
    queue_req(ACT_UPSERT, '1, 64'sd1);
    queue_req(ACT_ERASE, '0, '0);
    queue_req(ACT_ERASE, '0, '0);
    queue_req(ACT_SPARE_LO, '1, TIME_MAX);
    queue_req(ACT_SPARE_HI, '0, TIME_MIN);
    queue_req(ACT_LATEST, '0, '0);
    queue_drain();

    // small key set: many moves, equal times and erase hits
    repeat (100) request_q = {request_q, random_request(12, 35)};
    queue_drain();

    // fill past capacity
    for (int k = 0; k < 70; k++) begin
      queue_req(ACT_UPSERT, key_pool[k], pick_time());
      if (k % 10 == 9) queue_req((k % 20 == 9) ? ACT_BEFORE : ACT_AFTER, '0, pick_time());
    end
    queue_req(ACT_BEFORE, '0, TIME_MAX);
    queue_req(ACT_AFTER, '0, TIME_MIN);
    queue_req(ACT_LATEST, '0, '0);
    queue_req(ACT_UPSERT, key_pool[5], TIME_MAX);
    queue_req(ACT_UPSERT, {$urandom, $urandom}, pick_time());
    queue_req(ACT_ERASE, {$urandom, $urandom}, '0);
    queue_drain();

    // wide key set, erase-heavy
    repeat (110) request_q = {request_q, random_request(KEY_POOL_N, 18)};

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (request_q.size() != 0 || in_valid) @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (TABLE_DEPTH + 16) @(posedge clk);
    if (err_cnt == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
